FILE: rtl/core/e2q_pkg.sv
// Package for the Euler angle to quaternion converter.
// Holds the CORDIC lane types, fixed-point widths and the arctangent table.
// No dependencies.
`default_nettype none
package e2q_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int XW = 34;
    localparam int ZW = 34;
    localparam int QW = 32;
    localparam logic signed [XW-1:0] X_INIT = 34'sd652032874;
    localparam logic signed [XW-1:0] Q30_ONE = 34'sd1073741824;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    typedef t_lane [2:0] t_trio;

    function automatic logic signed [ZW-1:0] atan_unit(input int step);
        logic signed [ZW-1:0] v;
        case (step)
            0:  v = 34'sd1073741824;
            1:  v = 34'sd633866812;
            2:  v = 34'sd334917814;
            3:  v = 34'sd170009512;
            4:  v = 34'sd85334662;
            5:  v = 34'sd42708930;
            6:  v = 34'sd21359676;
            7:  v = 34'sd10680490;
            8:  v = 34'sd5340326;
            9:  v = 34'sd2670174;
            10: v = 34'sd1335088;
            11: v = 34'sd667544;
            12: v = 34'sd333772;
            13: v = 34'sd166886;
            14: v = 34'sd83444;
            15: v = 34'sd41722;
            16: v = 34'sd20860;
            17: v = 34'sd10430;
            18: v = 34'sd5216;
            19: v = 34'sd2608;
            20: v = 34'sd1304;
            21: v = 34'sd652;
            22: v = 34'sd326;
            23: v = 34'sd162;
            24: v = 34'sd82;
            25: v = 34'sd40;
            26: v = 34'sd20;
            27: v = 34'sd10;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/e2q_cell.sv
// One CORDIC rotation cell working on the three angle lanes at once.
// Depends on e2q_pkg for the lane types and the arctangent table.
`default_nettype none
module e2q_cell #(
    parameter int STEP = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  e2q_pkg::t_trio       i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output e2q_pkg::t_trio       o_data
);

    localparam logic signed [e2q_pkg::ZW-1:0] ATAN = e2q_pkg::atan_unit(STEP);

    logic           r_valid;
    e2q_pkg::t_trio r_data;
    e2q_pkg::t_trio n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!i_data[l].z[e2q_pkg::ZW-1]) begin
                n_data[l].x = i_data[l].x - (i_data[l].y >>> STEP);
                n_data[l].y = i_data[l].y + (i_data[l].x >>> STEP);
                n_data[l].z = i_data[l].z - ATAN;
            end else begin
                n_data[l].x = i_data[l].x + (i_data[l].y >>> STEP);
                n_data[l].y = i_data[l].y - (i_data[l].x >>> STEP);
                n_data[l].z = i_data[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: rtl/core/e2q_prod.sv
// Product pipeline: clamps sine and cosine, forms the triple products and
// rounds and saturates the four components. Depends on e2q_pkg.
`default_nettype none
module e2q_prod #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  e2q_pkg::t_trio                   i_data,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [COMPONENT_BITS-1:0] o_quat_w,
    output logic signed [COMPONENT_BITS-1:0] o_quat_x,
    output logic signed [COMPONENT_BITS-1:0] o_quat_y,
    output logic signed [COMPONENT_BITS-1:0] o_quat_z
);

    localparam int QW = e2q_pkg::QW;
    localparam logic signed [63:0] RND = 64'sd1 <<< (60 - COMPONENT_BITS);
    localparam logic signed [63:0] MAXV = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] MINV = -(64'sd1 <<< (COMPONENT_BITS - 1));

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy2, rdy3, rdy4;

    logic signed [QW-1:0] r_c [3];
    logic signed [QW-1:0] r_s [3];
    logic signed [31:0]   r_cycp, r_sysp, r_sycp, r_cysp;
    logic signed [QW-1:0] r_sr, r_cr;
    logic signed [62:0]   r_t [8];
    logic signed [COMPONENT_BITS-1:0] r_q [4];

    logic signed [QW-1:0] n_c [3];
    logic signed [QW-1:0] n_s [3];
    logic signed [61:0]   p_cycp, p_sysp, p_sycp, p_cysp;
    logic signed [63:0]   sum [4];
    logic signed [63:0]   rnd [4];
    logic signed [COMPONENT_BITS-1:0] n_q [4];

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = !r_v1 || rdy2;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (i_data[l].x > e2q_pkg::Q30_ONE) begin
                n_c[l] = QW'(e2q_pkg::Q30_ONE);
            end else if (i_data[l].x < -e2q_pkg::Q30_ONE) begin
                n_c[l] = QW'(-e2q_pkg::Q30_ONE);
            end else begin
                n_c[l] = QW'(i_data[l].x);
            end
            if (i_data[l].y > e2q_pkg::Q30_ONE) begin
                n_s[l] = QW'(e2q_pkg::Q30_ONE);
            end else if (i_data[l].y < -e2q_pkg::Q30_ONE) begin
                n_s[l] = QW'(-e2q_pkg::Q30_ONE);
            end else begin
                n_s[l] = QW'(i_data[l].y);
            end
        end
    end

    always_comb begin
        p_cycp = r_c[0] * r_c[1] + 62'sd536870912;
        p_sysp = r_s[0] * r_s[1] + 62'sd536870912;
        p_sycp = r_s[0] * r_c[1] + 62'sd536870912;
        p_cysp = r_c[0] * r_s[1] + 62'sd536870912;
    end

    always_comb begin
        sum[0] = 64'(r_t[0]) - 64'(r_t[1]);
        sum[1] = 64'(r_t[2]) + 64'(r_t[3]);
        sum[2] = 64'(r_t[4]) - 64'(r_t[5]);
        sum[3] = 64'(r_t[6]) + 64'(r_t[7]);
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (sum[k] + RND) >>> (61 - COMPONENT_BITS);
            if (rnd[k] > MAXV) begin
                n_q[k] = COMPONENT_BITS'(MAXV);
            end else if (rnd[k] < MINV) begin
                n_q[k] = COMPONENT_BITS'(MINV);
            end else begin
                n_q[k] = COMPONENT_BITS'(rnd[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_c <= n_c;
            r_s <= n_s;
        end
        if (rdy2 && r_v1) begin
            r_cycp <= p_cycp[61:30];
            r_sysp <= p_sysp[61:30];
            r_sycp <= p_sycp[61:30];
            r_cysp <= p_cysp[61:30];
            r_sr   <= r_s[2];
            r_cr   <= r_c[2];
        end
        if (rdy3 && r_v2) begin
            r_t[0] <= r_cycp * r_cr;
            r_t[1] <= r_sysp * r_sr;
            r_t[2] <= r_sycp * r_cr;
            r_t[3] <= r_cysp * r_sr;
            r_t[4] <= r_sycp * r_sr;
            r_t[5] <= r_cysp * r_cr;
            r_t[6] <= r_cycp * r_sr;
            r_t[7] <= r_sysp * r_cr;
        end
        if (rdy4 && r_v3) begin
            r_q <= n_q;
        end
    end

    assign o_valid  = r_v4;
    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];

endmodule
`default_nettype wire

FILE: rtl/core/euler_to_quaternion.sv
// Top level of the Euler angle to quaternion converter.
// Instantiates the chain of e2q_cell CORDIC cells and e2q_prod; uses e2q_pkg.
//
//   Channel  Direction  Handshake          Payload
//   in       sink       i_valid / o_stall  i_yaw_angle, i_pitch_angle, i_roll_angle
//   out      source     o_valid / i_stall  o_quat_w, o_quat_x, o_quat_y, o_quat_z
//
// One transaction is taken every cycle unless a stalled output has filled every stage;
// a result passes through the CORDIC cell chain and then the product pipeline.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output fills the empty stages before the input stalls.
// Synchronous active-low reset empties every stage.
`default_nettype none
module euler_to_quaternion #(
    parameter int ANGLE_BITS = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire signed [ANGLE_BITS-1:0]      i_yaw_angle,
    input  wire signed [ANGLE_BITS-1:0]      i_pitch_angle,
    input  wire signed [ANGLE_BITS-1:0]      i_roll_angle,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [COMPONENT_BITS-1:0] o_quat_w,
    output logic signed [COMPONENT_BITS-1:0] o_quat_x,
    output logic signed [COMPONENT_BITS-1:0] o_quat_y,
    output logic signed [COMPONENT_BITS-1:0] o_quat_z
);

    localparam int N = e2q_pkg::CORDIC_STEPS;

    logic           valid [N+1];
    logic           ready [N+1];
    e2q_pkg::t_trio data  [N+1];
    e2q_pkg::t_trio seed;

    always_comb begin
        seed[0].z = e2q_pkg::ZW'(i_yaw_angle) <<< (32 - ANGLE_BITS);
        seed[1].z = e2q_pkg::ZW'(i_pitch_angle) <<< (32 - ANGLE_BITS);
        seed[2].z = e2q_pkg::ZW'(i_roll_angle) <<< (32 - ANGLE_BITS);
        for (int l = 0; l < 3; l++) begin
            seed[l].x = e2q_pkg::X_INIT;
            seed[l].y = '0;
        end
    end

    assign data[0]  = seed;
    assign valid[0] = i_valid;
    assign o_stall  = !ready[0];

    for (genvar g = 0; g < N; g++) begin : g_cell
        e2q_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .o_ready (ready[g]),
            .i_data  (data[g]),
            .o_valid (valid[g+1]),
            .i_ready (ready[g+1]),
            .o_data  (data[g+1])
        );
    end

    e2q_prod #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (valid[N]),
        .o_ready  (ready[N]),
        .i_data   (data[N]),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled while the pipeline had room.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_nonzero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_quat_w == '0 && o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0))
        else $error("Quaternion result has zero norm.");

endmodule
`default_nettype wire

FILE: dv/euler_to_quaternion_tb.sv
// Testbench for the Euler angle to quaternion converter euler_to_quaternion.
// Predicts each quaternion with its own fixed-point CORDIC and checks every
// output transaction. Depends only on the RTL of the block.
module euler_to_quaternion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABITS = 16;
    localparam int CBITS = 16;
    localparam int STEPS = 28;
    localparam int LATENCY = 32;

    typedef struct packed {
        logic signed [CBITS-1:0] w;
        logic signed [CBITS-1:0] x;
        logic signed [CBITS-1:0] y;
        logic signed [CBITS-1:0] z;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [ABITS-1:0] i_yaw_angle = '0;
    logic signed [ABITS-1:0] i_pitch_angle = '0;
    logic signed [ABITS-1:0] i_roll_angle = '0;
    logic o_stall;
    logic o_valid;
    logic signed [CBITS-1:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    t_quat expected_quats[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    bit stall_enable = 1'b1;

    longint atan_tab[STEPS] = '{
        1073741824, 633866812, 334917814, 170009512, 85334662, 42708930,
        21359676, 10680490, 5340326, 2670174, 1335088, 667544,
        333772, 166886, 83444, 41722, 20860, 10430,
        5216, 2608, 1304, 652, 326, 162, 82, 40, 20, 10};

    euler_to_quaternion #(.ANGLE_BITS(ABITS), .COMPONENT_BITS(CBITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_yaw_angle(i_yaw_angle), .i_pitch_angle(i_pitch_angle),
        .i_roll_angle(i_roll_angle),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x),
        .o_quat_y(o_quat_y), .o_quat_z(o_quat_z)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic half_sin_cos(input logic signed [ABITS-1:0] ang,
                                output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(ang) <<< (32 - ABITS);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = (x > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) :
            (x < -(64'sd1 <<< 30)) ? -(64'sd1 <<< 30) : x;
        s = (y > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) :
            (y < -(64'sd1 <<< 30)) ? -(64'sd1 <<< 30) : y;
    endtask

    function automatic longint triple_q60(longint a, longint b, longint c);
        longint ab;
        ab = (a * b + (64'sd1 <<< 29)) >>> 30;
        return ab * c;
    endfunction

    function automatic logic signed [CBITS-1:0] round_component(longint q60);
        longint r;
        r = (q60 + (64'sd1 <<< (60 - CBITS))) >>> (61 - CBITS);
        if (r > (64'sd1 <<< (CBITS - 1)) - 1) r = (64'sd1 <<< (CBITS - 1)) - 1;
        if (r < -(64'sd1 <<< (CBITS - 1))) r = -(64'sd1 <<< (CBITS - 1));
        return r[CBITS-1:0];
    endfunction

    task automatic predict_quat(input logic signed [ABITS-1:0] yaw, pitch, roll,
                                output t_quat q);
        longint sy, cy, sp, cp, sr, cr;
        half_sin_cos(yaw, sy, cy);
        half_sin_cos(pitch, sp, cp);
        half_sin_cos(roll, sr, cr);
        q.w = round_component(triple_q60(cy, cp, cr) - triple_q60(sy, sp, sr));
        q.x = round_component(triple_q60(sy, cp, cr) + triple_q60(cy, sp, sr));
        q.y = round_component(triple_q60(sy, cp, sr) - triple_q60(cy, sp, cr));
        q.z = round_component(triple_q60(cy, cp, sr) + triple_q60(sy, sp, cr));
    endtask

    task automatic send_angles(input logic signed [ABITS-1:0] yaw, pitch, roll,
                               input int gap);
        t_quat q;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_quat(yaw, pitch, roll, q);
        i_valid <= 1'b1;
        i_yaw_angle <= yaw;
        i_pitch_angle <= pitch;
        i_roll_angle <= roll;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_quats.push_back(q);
        sent++;
    endtask

    // Output stall: a random count of stalled cycles before each transaction.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = stall_enable ? $urandom_range(0, 15) : 0;
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n && o_valid && !i_stall) begin
            received++;
            if (expected_quats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
                         $time, o_quat_w, o_quat_x, o_quat_y, o_quat_z);
            end else begin
                q = expected_quats.pop_front();
                if (q.w !== o_quat_w || q.x !== o_quat_x ||
                    q.y !== o_quat_y || q.z !== o_quat_z) begin
                    errors++;
                    $display({"%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d",
                              " actual w=%0d x=%0d y=%0d z=%0d"},
                             $time, q.w, q.x, q.y, q.z,
                             o_quat_w, o_quat_x, o_quat_y, o_quat_z);
                end
            end
        end
    end

    task automatic test_directed();
        logic signed [ABITS-1:0] corners[8] = '{16'sh8000, 16'sh7fff, 16'sh0000,
            16'shffff, 16'sh0001, 16'sh4000, 16'shc000, 16'sh2000};
        for (int i = 0; i < 8; i++) send_angles(corners[i], corners[i], corners[i], 0);
        send_angles(16'sh8000, 16'sh0000, 16'sh0000, 1);
        send_angles(16'sh0000, 16'sh8000, 16'sh0000, 0);
        send_angles(16'sh0000, 16'sh0000, 16'sh8000, 2);
        send_angles(16'sh8000, 16'sh8000, 16'sh0000, 0);
        send_angles(16'sh7fff, 16'sh8000, 16'sh7fff, 0);
        send_angles(16'sh4000, 16'sh4000, 16'sh4000, 3);
        send_angles(16'shc000, 16'sh4000, 16'shc000, 0);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555, 0);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa, 0);
    endtask

    task automatic test_random();
        for (int n = 0; n < 600; n++)
            send_angles(ABITS'($urandom), ABITS'($urandom), ABITS'($urandom),
                        $urandom_range(0, 15));
    endtask

    task automatic test_back_to_back();
        stall_enable = 1'b0;
        for (int n = 0; n < 100; n++)
            send_angles(ABITS'($urandom), ABITS'($urandom), ABITS'($urandom), 0);
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_back_to_back();
        i_valid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Sent %0d angle triples and checked %0d quaternions, with random gaps and stalls.",
                 sent, received);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
